>>> sv/dsc_pkg.sv
// shared constants, types and codes for the diffusion stencil coefficient block
package dsc_pkg;

   localparam int DATA_W     = 32;
   localparam int CELL_W     = 17;
   localparam int CELL_IDX_W = 16;
   localparam int GROUP_W    = 4;
   localparam int ALB_W      = 17;
   localparam int ROW_W      = 20;
   localparam int COEF_W     = 48;
   localparam int MAX_CELLS  = 65536;
   localparam int MAX_GROUPS = 16;

   localparam logic [ALB_W-1:0] UNIT_Q16 = ALB_W'(65536);

   // quotient bits kept before saturation, and operand widths of the divide
   localparam int Q_BITS    = COEF_W - 1;
   localparam int NUM_SHIFT = 41;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int NUM_W     = PROD_W + NUM_SHIFT;
   localparam int DEN_W     = SUM_W + DATA_W;
   localparam int CMP_W     = DEN_W + Q_BITS;

   localparam logic [COEF_W-1:0] MAG_MAX = {1'b0, {(COEF_W-1){1'b1}}};

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam int OPND_LAT = 4;
   localparam int DIV_LAT  = Q_BITS + 1;
   localparam int PIPE_LAT = OPND_LAT + DIV_LAT;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BOUNDARY  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] own_diffusion;
      logic [DATA_W-1:0] own_width;
      logic [DATA_W-1:0] lower_diffusion;
      logic [DATA_W-1:0] lower_width;
      logic [DATA_W-1:0] upper_diffusion;
      logic [DATA_W-1:0] upper_width;
      logic              has_lower;
      logic              has_upper;
      logic [ALB_W-1:0]  albedo;
      logic [DATA_W-1:0] removal_term;
      logic [ROW_W-1:0]  row_index;
   } req_word_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row_index;
      logic              has_lower;
      logic              has_upper;
      logic [DATA_W-1:0] removal_term;
   } side_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

>>> sv/dsc_if.sv
// request and response channel interfaces
interface dsc_req_if;
   logic                                valid;
   logic                                ready;
   logic [dsc_pkg::DATA_W-1:0]          own_diffusion;
   logic [dsc_pkg::DATA_W-1:0]          own_width;
   logic [dsc_pkg::DATA_W-1:0]          lower_diffusion;
   logic [dsc_pkg::DATA_W-1:0]          lower_width;
   logic [dsc_pkg::DATA_W-1:0]          upper_diffusion;
   logic [dsc_pkg::DATA_W-1:0]          upper_width;
   logic                                has_lower;
   logic                                has_upper;
   logic [dsc_pkg::ALB_W-1:0]           boundary_albedo;
   logic [dsc_pkg::DATA_W-1:0]          removal_term;
   logic [dsc_pkg::CELL_IDX_W-1:0]      cell_req;
   logic [dsc_pkg::GROUP_W-1:0]         group;

   modport source (
      output valid, own_diffusion, own_width, lower_diffusion, lower_width,
             upper_diffusion, upper_width, has_lower, has_upper, boundary_albedo,
             removal_term, cell_req, group,
      input  ready
   );
   modport sink (
      input  valid, own_diffusion, own_width, lower_diffusion, lower_width,
             upper_diffusion, upper_width, has_lower, has_upper, boundary_albedo,
             removal_term, cell_req, group,
      output ready
   );
endinterface

interface dsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dsc_pkg::ROW_W-1:0]          row_index;
   logic signed [dsc_pkg::COEF_W-1:0]  coef_lower;
   logic signed [dsc_pkg::COEF_W-1:0]  coef_center;
   logic signed [dsc_pkg::COEF_W-1:0]  coef_upper;
   logic [1:0]                         status;

   modport source (
      output valid, row_index, coef_lower, coef_center, coef_upper, status,
      input  ready
   );
   modport sink (
      input  valid, row_index, coef_lower, coef_center, coef_upper, status,
      output ready
   );
endinterface

>>> sv/dsc_front.sv
// front end: accepts request words, holds cell_count, forms the row index
module dsc_front (
   input  logic                         clock,
   input  logic                         reset,
   dsc_req_if.sink                      req_chan,
   input  logic                         csr_wr_en,
   input  logic [dsc_pkg::CELL_W-1:0]   csr_wr_data,
   input  dsc_pkg::queue_stat_type      queue_stat,
   output logic                         queue_push,
   output dsc_pkg::req_word_type        queue_word
);

   localparam int PROD_W = dsc_pkg::GROUP_W + dsc_pkg::CELL_W;

   logic [dsc_pkg::CELL_W-1:0]  cell_count_ff, cell_count_in;
   logic [dsc_pkg::GROUP_W-1:0] group_eff;
   logic [PROD_W-1:0]           row_sum;

   always_comb begin
      cell_count_in = cell_count_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            cell_count_in = dsc_pkg::CELL_W'(1);
         end else if (32'(csr_wr_data) > dsc_pkg::MAX_CELLS) begin
            cell_count_in = dsc_pkg::CELL_W'(dsc_pkg::MAX_CELLS);
         end else begin
            cell_count_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= dsc_pkg::CELL_W'(1);
      end else begin
         cell_count_ff <= cell_count_in;
      end
   end

   always_comb begin
      if (32'(req_chan.group) >= dsc_pkg::MAX_GROUPS) begin
         group_eff = dsc_pkg::GROUP_W'(dsc_pkg::MAX_GROUPS - 1);
      end else begin
         group_eff = req_chan.group;
      end
      row_sum = PROD_W'(group_eff) * PROD_W'(cell_count_ff) + PROD_W'(req_chan.cell_req);

      queue_word.own_diffusion   = req_chan.own_diffusion;
      queue_word.own_width       = req_chan.own_width;
      queue_word.lower_diffusion = req_chan.lower_diffusion;
      queue_word.lower_width     = req_chan.lower_width;
      queue_word.upper_diffusion = req_chan.upper_diffusion;
      queue_word.upper_width     = req_chan.upper_width;
      queue_word.has_lower       = req_chan.has_lower;
      queue_word.has_upper       = req_chan.has_upper;
      // albedo above one counts as one
      queue_word.albedo          = (req_chan.boundary_albedo > dsc_pkg::UNIT_Q16) ?
                                   dsc_pkg::UNIT_Q16 : req_chan.boundary_albedo;
      queue_word.removal_term    = req_chan.removal_term;
      queue_word.row_index       = row_sum[dsc_pkg::ROW_W-1:0];
   end

   assign req_chan.ready = !queue_stat.full;
   assign queue_push     = req_chan.valid && !queue_stat.full;

endmodule

>>> sv/dsc_queue.sv
// short word queue between the front end and the arithmetic pipeline
module dsc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dsc_pkg::req_word_type    word_in,
   input  logic                     pop,
   output dsc_pkg::req_word_type    word_out,
   output dsc_pkg::queue_stat_type  stat
);

   dsc_pkg::req_word_type          entries_ff [dsc_pkg::QUEUE_DEPTH];
   logic [dsc_pkg::QPTR_W-1:0]     wptr_ff, wptr_in;
   logic [dsc_pkg::QPTR_W-1:0]     rptr_ff, rptr_in;
   logic [dsc_pkg::QPTR_W:0]       count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= word_in;
      end
   end

   assign word_out   = entries_ff[rptr_ff];
   assign stat.full  = (count_ff == (dsc_pkg::QPTR_W+1)'(dsc_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full) else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty) else $error("queue read while empty");

endmodule

>>> sv/dsc_opnd.sv
// forms the dividend and divisor of one coupling or boundary term
module dsc_opnd (
   input  logic                         clock,
   input  logic                         en,
   input  logic                         coupling,
   input  logic [dsc_pkg::DATA_W-1:0]   dm,
   input  logic [dsc_pkg::DATA_W-1:0]   wm,
   input  logic [dsc_pkg::DATA_W-1:0]   dn,
   input  logic [dsc_pkg::DATA_W-1:0]   wn,
   input  logic [dsc_pkg::ALB_W-1:0]    albedo,
   output logic [dsc_pkg::NUM_W-1:0]    num,
   output logic [dsc_pkg::DEN_W-1:0]    den
);

   localparam int DW  = dsc_pkg::DATA_W;
   localparam int PW  = dsc_pkg::PROD_W;
   localparam int SW  = dsc_pkg::SUM_W;
   localparam int HW  = SW - DW;
   localparam int HPW = HW + DW;

   logic [dsc_pkg::ALB_W-1:0] p_val;
   logic [dsc_pkg::ALB_W:0]   q_val;
   logic [DW-1:0]             y_shared, y_a;

   logic [PW-1:0]  prod_num_ff, prod_num_in, prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic           coup_ff;
   logic [DW-1:0]  wm1_ff, wm2_ff;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [PW-1:0]  num2_ff, num3_ff;
   logic [PW-1:0]  lo_ff, lo_in;
   logic [HPW-1:0] hi_ff, hi_in;
   logic [dsc_pkg::NUM_W-1:0] num_ff;
   logic [dsc_pkg::DEN_W-1:0] den_ff, den_in;

   // boundary: R = p / q with p = 1 - albedo, q = 1 + albedo
   always_comb begin
      p_val       = dsc_pkg::UNIT_Q16 - albedo;
      q_val       = {1'b0, dsc_pkg::UNIT_Q16} + {1'b0, albedo};
      y_shared    = coupling ? dn : DW'(p_val);
      y_a         = coupling ? wn : DW'(q_val);
      prod_num_in = PW'(dm) * PW'(y_shared);
      prod_a_in   = PW'(dm) * PW'(y_a);
      prod_b_in   = PW'(y_shared) * PW'(wm);
   end

   always_comb begin
      if (coup_ff) begin
         sum_in = SW'(prod_a_ff) + SW'(prod_b_ff);
      end else begin
         sum_in = (SW'(prod_a_ff) << 2) + SW'(prod_b_ff);
      end
      lo_in  = PW'(sum_ff[DW-1:0]) * PW'(wm2_ff);
      hi_in  = HPW'(sum_ff[SW-1:DW]) * HPW'(wm2_ff);
      den_in = {hi_ff, DW'(0)} + dsc_pkg::DEN_W'(lo_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_num_ff <= prod_num_in;
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
         coup_ff     <= coupling;
         wm1_ff      <= wm;

         sum_ff      <= sum_in;
         num2_ff     <= prod_num_ff;
         wm2_ff      <= wm1_ff;

         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         num3_ff     <= num2_ff;

         den_ff      <= den_in;
         num_ff      <= {num3_ff, dsc_pkg::NUM_SHIFT'(0)};
      end
   end

   assign num = num_ff;
   assign den = den_ff;

endmodule

>>> sv/dsc_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
module dsc_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [dsc_pkg::NUM_W-1:0]    num,
   input  logic [dsc_pkg::DEN_W-1:0]    den,
   output logic [dsc_pkg::COEF_W-1:0]   mag,
   output logic                         sat
);

   localparam int QB = dsc_pkg::Q_BITS;
   localparam int CW = dsc_pkg::CMP_W;
   localparam int NW = dsc_pkg::NUM_W;

   logic [NW-1:0]               rem_ff  [0:QB];
   logic [dsc_pkg::DEN_W-1:0]   dvs_ff  [0:QB];
   logic [QB-1:0]               quo_ff  [0:QB];
   logic                        zero_ff [0:QB];
   logic                        sat_ff  [0:QB];

   logic [CW-1:0]  shifted [1:QB];
   logic           ge      [1:QB];
   logic [NW-1:0]  rem_in  [1:QB];
   logic [QB-1:0]  quo_in  [1:QB];
   logic           zero_in, sat_in;

   // a zero divisor also trips the overflow compare
   always_comb begin
      zero_in = (num == '0);
      sat_in  = !zero_in && ({den, QB'(0)} <= CW'(num));
      for (int j = 1; j <= QB; j++) begin
         shifted[j] = CW'(dvs_ff[j-1]) << (QB - j);
         ge[j]      = CW'(rem_ff[j-1]) >= shifted[j];
         rem_in[j]  = ge[j] ? rem_ff[j-1] - shifted[j][NW-1:0] : rem_ff[j-1];
         quo_in[j]  = {quo_ff[j-1][QB-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num;
         dvs_ff[0]  <= den;
         quo_ff[0]  <= '0;
         zero_ff[0] <= zero_in;
         sat_ff[0]  <= sat_in;
         for (int j = 1; j <= QB; j++) begin
            rem_ff[j]  <= rem_in[j];
            dvs_ff[j]  <= dvs_ff[j-1];
            quo_ff[j]  <= quo_in[j];
            zero_ff[j] <= zero_ff[j-1];
            sat_ff[j]  <= sat_ff[j-1];
         end
      end
   end

   always_comb begin
      if (zero_ff[QB]) begin
         mag = '0;
      end else if (sat_ff[QB]) begin
         mag = dsc_pkg::MAG_MAX;
      end else begin
         mag = {1'b0, quo_ff[QB]};
      end
   end

   assign sat = sat_ff[QB];

endmodule

>>> sv/diffusion_stencil_coefficients_top.sv
// top level: diffusion stencil coefficients, front end, queue, divide pipeline
//
//   channel   dir   handshake          word
//   req_chan  in    valid/ready        one cell and group, both neighbours
//   rsp_chan  out   valid/ready        row index, three coefficients, status
//   csr       in    csr_wr_en          cell_count, no read-back
//
// one word per cycle sustained while the response is taken; queue head to response
// register via operand stages, the 47-stage quotient pipeline and the check stage
// reset is synchronous and clears the queue, stage valids and cell_count (to 1)
// a stalled response freezes the whole pipeline; the 4-entry queue takes words until full
module diffusion_stencil_coefficients_top (
   input  logic                         clock,
   input  logic                         reset,
   dsc_req_if.sink                      req_chan,
   dsc_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [dsc_pkg::CELL_W-1:0]   csr_wr_data
);

   localparam int LAT = dsc_pkg::PIPE_LAT;
   localparam int CW  = dsc_pkg::COEF_W;
   localparam int SUM_CW = CW + 2;

   dsc_pkg::req_word_type    push_word, head;
   dsc_pkg::queue_stat_type  queue_stat;
   logic                     push, pop, en;

   logic [dsc_pkg::NUM_W-1:0] num_a, num_b;
   logic [dsc_pkg::DEN_W-1:0] den_a, den_b;
   logic [CW-1:0]             mag_a, mag_b;
   logic                      sat_a, sat_b;

   logic              valid_ff [0:LAT-1];
   dsc_pkg::side_type side_ff  [0:LAT-1];
   dsc_pkg::side_type side_head, side_last;

   logic [SUM_CW-1:0]     center_sum;
   logic                  center_ovf;
   logic [CW-1:0]         lower_in, center_in, upper_in;
   dsc_pkg::status_type   status_in;

   logic                  rsp_valid_ff;
   logic [dsc_pkg::ROW_W-1:0] rsp_row_ff;
   logic [CW-1:0]         rsp_lower_ff, rsp_center_ff, rsp_upper_ff;
   dsc_pkg::status_type   rsp_status_ff;

   dsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_stat  (queue_stat),
      .queue_push  (push),
      .queue_word  (push_word)
   );

   dsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .word_in  (push_word),
      .pop      (pop),
      .word_out (head),
      .stat     (queue_stat)
   );

   assign en  = !rsp_valid_ff || rsp_chan.ready;
   assign pop = en && !queue_stat.empty;

   // lower lane: lower coupling, or the boundary term when the lower side is open
   dsc_opnd u_opnd_lower (
      .clock    (clock),
      .en       (en),
      .coupling (head.has_lower),
      .dm       (head.own_diffusion),
      .wm       (head.own_width),
      .dn       (head.lower_diffusion),
      .wn       (head.lower_width),
      .albedo   (head.albedo),
      .num      (num_a),
      .den      (den_a)
   );

   dsc_opnd u_opnd_upper (
      .clock    (clock),
      .en       (en),
      .coupling (head.has_upper),
      .dm       (head.own_diffusion),
      .wm       (head.own_width),
      .dn       (head.upper_diffusion),
      .wn       (head.upper_width),
      .albedo   (head.albedo),
      .num      (num_b),
      .den      (den_b)
   );

   dsc_div u_div_lower (
      .clock (clock),
      .en    (en),
      .num   (num_a),
      .den   (den_a),
      .mag   (mag_a),
      .sat   (sat_a)
   );

   dsc_div u_div_upper (
      .clock (clock),
      .en    (en),
      .num   (num_b),
      .den   (den_b),
      .mag   (mag_b),
      .sat   (sat_b)
   );

   always_comb begin
      side_head.row_index    = head.row_index;
      side_head.has_lower    = head.has_lower;
      side_head.has_upper    = head.has_upper;
      side_head.removal_term = head.removal_term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= pop;
         for (int i = 1; i < LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_head;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign side_last = side_ff[LAT-1];

   // removal enters as Q16.16, shifted up by eight to the Q24.24 of the coefficients
   always_comb begin
      center_sum = SUM_CW'(mag_a) + SUM_CW'(mag_b)
                 + (SUM_CW'(side_last.removal_term) << 8);
      center_ovf = center_sum > SUM_CW'(dsc_pkg::MAG_MAX);
      if (!side_last.has_lower && !side_last.has_upper) begin
         lower_in  = '0;
         center_in = '0;
         upper_in  = '0;
         status_in = dsc_pkg::STATUS_BOUNDARY;
      end else begin
         lower_in  = side_last.has_lower ? CW'(0) - mag_a : '0;
         upper_in  = side_last.has_upper ? CW'(0) - mag_b : '0;
         center_in = center_ovf ? dsc_pkg::MAG_MAX : center_sum[CW-1:0];
         status_in = (sat_a || sat_b || center_ovf) ?
                     dsc_pkg::STATUS_SATURATED : dsc_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_row_ff    <= side_last.row_index;
         rsp_lower_ff  <= lower_in;
         rsp_center_ff <= center_in;
         rsp_upper_ff  <= upper_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.row_index   = rsp_row_ff;
   assign rsp_chan.coef_lower  = rsp_lower_ff;
   assign rsp_chan.coef_center = rsp_center_ff;
   assign rsp_chan.coef_upper  = rsp_upper_ff;
   assign rsp_chan.status      = rsp_status_ff;

   a_boundary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == dsc_pkg::STATUS_BOUNDARY |->
      rsp_lower_ff == '0 && rsp_center_ff == '0 && rsp_upper_ff == '0)
      else $error("nonzero coefficient with both sides open");
   a_center_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_center_ff[CW-1])
      else $error("negative centre coefficient");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff[LAT-1]))
      else $error("pipeline moved during a stall");

endmodule
